@@ sv/bpcf_pkg.sv @@
// Shared types, constants and register codes for the box peak charge finder.
`default_nettype none

package bpcf_pkg;

  localparam int SLICES_DEF  = 4;
  localparam int SLICE_NUM_W = 4;
  localparam int BOX_W       = 6;
  localparam logic [BOX_W-1:0] MAX_BOX = 6'd63;
  localparam int CMD_DEPTH   = 4;
  localparam int RES_DEPTH   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [15:0] ADC_THRESHOLD_RST = 16'd27500;
  localparam logic [13:0] FIRST_CHANNEL_RST = 14'd4800;
  localparam logic [13:0] LAST_CHANNEL_RST  = 14'd8255;
  localparam logic [9:0]  BOX_CHANNELS_RST  = 10'd96;
  localparam logic [31:0] TIME_ORIGIN_RST   = 32'd3200;
  localparam logic [15:0] SLICE_TICKS_RST   = 16'd1150;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_THRESHOLD = 3'd0,
    REG_FIRST_CHANNEL = 3'd1,
    REG_LAST_CHANNEL  = 3'd2,
    REG_BOX_CHANNELS  = 3'd3,
    REG_TIME_ORIGIN   = 3'd4,
    REG_SLICE_TICKS   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [13:0] channel;
    logic [31:0] start_tick;
    logic [15:0] charge_integral;
    logic [15:0] charge_peak;
    logic [15:0] duration;
    logic        end_of_list;
  } in_item_t;

  typedef struct packed {
    logic [13:0] hit_channel;
    logic [31:0] hit_start;
    logic [15:0] hit_charge;
    logic [15:0] hit_peak;
    logic [15:0] hit_duration;
    logic [3:0]  slice_number;
    logic        run_end;
  } out_item_t;

  typedef struct packed {
    logic [15:0] adc_threshold;
    logic [13:0] first_channel;
    logic [13:0] last_channel;
    logic [9:0]  box_channels;
    logic [31:0] time_origin;
    logic [15:0] slice_ticks;
  } cfg_t;

  // Classified hit handed from the front end to the back end.
  typedef struct packed {
    in_item_t                hit;
    logic [SLICE_NUM_W-1:0]  slice;
    logic                    in_slice;
    logic                    close;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_HEAD,
    BK_FLUSH_OLD,
    BK_FLUSH_EOL,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

@@ sv/bpcf_fifo.sv @@
// Small register-based FIFO used between the stages and at the result port.
`default_nettype none

module bpcf_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire T     wdata,
  output logic      full,
  input  wire logic pop,
  output T          rdata,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  T                mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ sv/bpcf_front.sv @@
// Front end: takes hits, walks the box grid and sorts each hit into a time slice.
`default_nettype none

module bpcf_front #(
  parameter int SLICES = bpcf_pkg::SLICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bpcf_pkg::cfg_t    cfg,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire bpcf_pkg::in_item_t in_data,
  output logic                   cmd_push,
  input  wire logic              cmd_full,
  output bpcf_pkg::cmd_t         cmd_data
);

  import bpcf_pkg::*;

  logic              hold_v_r;
  in_item_t          hold_r;
  logic [BOX_W-1:0]  box_r;
  logic              stepped_r;

  logic [9:0]        width;
  logic [15:0]       span;
  logic [16:0]       edge_pos;
  logic              done;
  logic              load;
  logic [32:0]       dt;
  logic [SLICES-1:0] ge;
  logic [SLICE_NUM_W-1:0] slice_cnt;

  assign width    = (cfg.box_channels == '0) ? 10'd1 : cfg.box_channels;
  assign span     = 16'(box_r) * 16'(width);
  assign edge_pos = 17'(cfg.first_channel) + 17'(span);

  // The open box holds the hit once its upper edge reaches the channel, or the
  // grid has run out.
  assign done = (edge_pos >= 17'(hold_r.channel)) ||
                (edge_pos >= 17'(cfg.last_channel)) ||
                (box_r == MAX_BOX);

  assign cmd_push = hold_v_r && done && !cmd_full;
  assign in_full  = hold_v_r && !cmd_push;
  assign load     = in_push && !in_full;

  assign dt = {1'b0, hold_r.start_tick} - {1'b0, cfg.time_origin};

  // ge[k] is set when the hit lies at or beyond the end of slice k.
  always_comb begin
    for (int k = 0; k < SLICES; k++) begin
      ge[k] = !dt[32] && (dt[31:0] >= 32'(21'(k + 1) * 21'(cfg.slice_ticks)));
    end
  end

  always_comb begin
    slice_cnt = '0;
    for (int k = 0; k < SLICES - 1; k++) begin
      slice_cnt = slice_cnt + SLICE_NUM_W'(ge[k]);
    end
  end

  always_comb begin
    cmd_data.hit      = hold_r;
    cmd_data.slice    = slice_cnt;
    cmd_data.in_slice = !dt[32] && !ge[SLICES-1];
    cmd_data.close    = stepped_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r  <= 1'b0;
      box_r     <= BOX_W'(1);
      stepped_r <= 1'b0;
    end else begin
      if (load) begin
        hold_v_r <= 1'b1;
      end else if (cmd_push) begin
        hold_v_r <= 1'b0;
      end
      if (cmd_push && hold_r.end_of_list) begin
        box_r <= BOX_W'(1);
      end else if (hold_v_r && !done) begin
        box_r <= box_r + 1'b1;
      end
      if (load) begin
        stepped_r <= 1'b0;
      end else if (hold_v_r && !done) begin
        stepped_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= in_data;
    end
  end

endmodule

`default_nettype wire

@@ sv/bpcf_back.sv @@
// Back end: keeps the per-slice maxima and flushes them when a box closes or the list ends.
`default_nettype none

module bpcf_back #(
  parameter int SLICES = bpcf_pkg::SLICES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     adc_threshold,
  input  wire logic            cmd_empty,
  output logic                 cmd_pop,
  input  wire bpcf_pkg::cmd_t  cmd_data,
  output logic                 res_push,
  input  wire logic            res_full,
  output bpcf_pkg::out_item_t  res_data
);

  import bpcf_pkg::*;

  localparam int SW = (SLICES > 1) ? $clog2(SLICES) : 1;

  back_state_t      state_r, state_nxt;
  logic [SW-1:0]    scan_r, scan_nxt;
  logic             closed_r, closed_nxt;
  logic             pend_v_r;
  out_item_t        pend_r;

  logic [15:0]      max_r      [SLICES];
  logic [13:0]      best_ch    [SLICES];
  logic [31:0]      best_start [SLICES];
  logic [15:0]      best_peak  [SLICES];
  logic [15:0]      best_dur   [SLICES];

  logic             hv, opening, last_scan, emit, stall, go;
  logic [SW-1:0]    rd_idx;
  logic [15:0]      rd_max;
  logic             upd_we, clr_we, emit_go, end_item;

  assign hv        = !cmd_empty;
  assign opening   = cmd_data.close && !closed_r;
  assign last_scan = (scan_r == SW'(SLICES - 1));
  assign rd_idx    = (state_r == BK_HEAD) ? cmd_data.slice[SW-1:0] : scan_r;
  assign rd_max    = max_r[rd_idx];
  assign emit      = rd_max > adc_threshold;

  // A transfer to the result queue is only needed when a held result exists.
  always_comb begin
    unique case (state_r)
      BK_HEAD:      stall = hv && !opening && !cmd_data.hit.end_of_list &&
                            pend_v_r && res_full;
      BK_FLUSH_OLD,
      BK_FLUSH_EOL: stall = emit && pend_v_r && res_full;
      BK_DONE:      stall = pend_v_r && res_full;
      default:      stall = 1'b1;
    endcase
  end
  assign go = !stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_HEAD: begin
        if (hv && opening) begin
          state_nxt = BK_FLUSH_OLD;
        end else if (hv && cmd_data.hit.end_of_list) begin
          state_nxt = BK_FLUSH_EOL;
        end
      end
      BK_FLUSH_OLD: begin
        if (go && last_scan) begin
          state_nxt = BK_HEAD;
        end
      end
      BK_FLUSH_EOL: begin
        if (go && last_scan) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (go) begin
          state_nxt = BK_HEAD;
        end
      end
      default: state_nxt = BK_HEAD;
    endcase
  end

  always_comb begin
    upd_we     = 1'b0;
    clr_we     = 1'b0;
    emit_go    = 1'b0;
    end_item   = 1'b0;
    cmd_pop    = 1'b0;
    scan_nxt   = '0;
    closed_nxt = closed_r;
    unique case (state_r)
      BK_HEAD: begin
        if (hv && !opening) begin
          if (cmd_data.hit.end_of_list) begin
            upd_we = cmd_data.in_slice && (cmd_data.hit.charge_integral > rd_max);
          end else begin
            upd_we   = go && cmd_data.in_slice &&
                       (cmd_data.hit.charge_integral > rd_max);
            end_item = go;
            cmd_pop  = go;
          end
        end
      end
      BK_FLUSH_OLD,
      BK_FLUSH_EOL: begin
        clr_we  = go;
        emit_go = go && emit;
        if (go && !last_scan) begin
          scan_nxt = scan_r + 1'b1;
        end else if (!go) begin
          scan_nxt = scan_r;
        end
        if (go && last_scan && (state_r == BK_FLUSH_OLD)) begin
          closed_nxt = 1'b1;
        end
      end
      BK_DONE: begin
        end_item = go;
        cmd_pop  = go;
      end
      default: begin
      end
    endcase
    if (cmd_pop) begin
      closed_nxt = 1'b0;
    end
  end

  assign res_push = (emit_go || end_item) && pend_v_r;
  always_comb begin
    res_data         = pend_r;
    res_data.run_end = end_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_HEAD;
      scan_r   <= '0;
      closed_r <= 1'b0;
      pend_v_r <= 1'b0;
      for (int s = 0; s < SLICES; s++) begin
        max_r[s] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      scan_r   <= scan_nxt;
      closed_r <= closed_nxt;
      if (emit_go) begin
        pend_v_r <= 1'b1;
      end else if (end_item) begin
        pend_v_r <= 1'b0;
      end
      if (upd_we) begin
        max_r[rd_idx] <= cmd_data.hit.charge_integral;
      end else if (clr_we) begin
        max_r[scan_r] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_we) begin
      best_ch[rd_idx]    <= cmd_data.hit.channel;
      best_start[rd_idx] <= cmd_data.hit.start_tick;
      best_peak[rd_idx]  <= cmd_data.hit.charge_peak;
      best_dur[rd_idx]   <= cmd_data.hit.duration;
    end
    if (emit_go) begin
      pend_r.hit_channel  <= best_ch[scan_r];
      pend_r.hit_start    <= best_start[scan_r];
      pend_r.hit_charge   <= rd_max;
      pend_r.hit_peak     <= best_peak[scan_r];
      pend_r.hit_duration <= best_dur[scan_r];
      pend_r.slice_number <= SLICE_NUM_W'(scan_r);
      pend_r.run_end      <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ sv/box_peak_charge_finder.sv @@
// Top level of the box peak charge finder: registers, front end, back end, queues.
//
//   channel  direction  handshake                    payload
//   in       input      in_push / in_full            in_data  (in_item_t)
//   out      output     out_pop / out_empty          out_data (out_item_t)
//   cfg      input      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A hit that stays in the open box passes through the front end and then the back
// end. Moving the box grid makes the front step one box at a time. A box flush
// scans every slice in the back end, so a hit that both closes a box and ends
// the list flushes twice. A full result queue stalls the back end only when a
// further result must move on; the command queue lets the front keep accepting.
// Reset is synchronous and restores the configuration registers and clears the maxima.
`default_nettype none

module box_peak_charge_finder #(
  parameter int SLICES = bpcf_pkg::SLICES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire bpcf_pkg::in_item_t                 in_data,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output bpcf_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bpcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bpcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import bpcf_pkg::*;

  cfg_t      cfg_r;
  logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t      cmd_wdata, cmd_rdata;
  logic      res_push, res_full;
  out_item_t res_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.adc_threshold <= ADC_THRESHOLD_RST;
      cfg_r.first_channel <= FIRST_CHANNEL_RST;
      cfg_r.last_channel  <= LAST_CHANNEL_RST;
      cfg_r.box_channels  <= BOX_CHANNELS_RST;
      cfg_r.time_origin   <= TIME_ORIGIN_RST;
      cfg_r.slice_ticks   <= SLICE_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ADC_THRESHOLD: cfg_r.adc_threshold <= cfg_data[15:0];
        REG_FIRST_CHANNEL: cfg_r.first_channel <= cfg_data[13:0];
        REG_LAST_CHANNEL:  cfg_r.last_channel  <= cfg_data[13:0];
        REG_BOX_CHANNELS:  cfg_r.box_channels  <= cfg_data[9:0];
        REG_TIME_ORIGIN:   cfg_r.time_origin   <= cfg_data[31:0];
        REG_SLICE_TICKS:   cfg_r.slice_ticks   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  bpcf_front #(.SLICES(SLICES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full),
    .cmd_data (cmd_wdata)
  );

  bpcf_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  bpcf_back #(.SLICES(SLICES)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .adc_threshold (cfg_r.adc_threshold),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .cmd_data      (cmd_rdata),
    .res_push      (res_push),
    .res_full      (res_full),
    .res_data      (res_wdata)
  );

  bpcf_fifo #(.T(out_item_t), .DEPTH(RES_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

`default_nettype wire
